// File: hw/rtl/itra_pkg.sv
// Shared types, constants and the digit glyph function for the integer to
// radix ASCII converter. No dependencies.

package itra_pkg;

  // Field and register widths fixed by the interface.
  localparam int RADIX_W = 5;
  localparam int DIGIT_W = 4;
  localparam int CHAR_W  = 7;

  // Radix register reset value and the range the converter actually uses.
  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

  // Quotient bits resolved per divider cycle.
  localparam int CHUNK_BITS = 8;

  // Depth of the job queue between front and back (power of two).
  localparam int QUEUE_DEPTH = 2;

  // ASCII anchors for the digit glyphs.
  localparam logic [CHAR_W-1:0]  CHAR_ZERO   = 7'h30;
  localparam logic [CHAR_W-1:0]  CHAR_UPPERA = 7'h41;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN   = 4'd10;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Digit value to upper-case ASCII character.
  function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DIGIT_TEN) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else begin
      c = CHAR_UPPERA + CHAR_W'(d - DIGIT_TEN);
    end
    return c;
  endfunction

endpackage

// File: hw/rtl/itra_front.sv
// Front end of the converter: radix register, command intake and radix
// clamping. Depends on itra_pkg.

module itra_front #(
  parameter int VALUE_BITS = 31
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [VALUE_BITS-1:0]        value,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [itra_pkg::RADIX_W-1:0] cfg_radix,
  input  itra_pkg::q_status_t          q_status,
  output logic                         push,
  output logic [VALUE_BITS-1:0]        push_value,
  output logic [itra_pkg::RADIX_W-1:0] push_radix
);

  logic [itra_pkg::RADIX_W-1:0] radix;

  // The radix register takes every configuration word.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= itra_pkg::RADIX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      radix <= cfg_radix;
    end
  end

  // Bring out-of-range radix values into the supported range.
  always_comb begin
    if (radix < itra_pkg::RADIX_MIN) begin
      push_radix = itra_pkg::RADIX_MIN;
    end else if (radix > itra_pkg::RADIX_MAX) begin
      push_radix = itra_pkg::RADIX_MAX;
    end else begin
      push_radix = radix;
    end
  end

  // A command word is taken whenever the job queue has room.
  assign busy       = q_status.full;
  assign push       = start && !q_status.full;
  assign push_value = value;

endmodule

// File: hw/rtl/itra_queue.sv
// Small job queue that decouples command intake from conversion.
// Depends on itra_pkg.

module itra_queue #(
  parameter int WIDTH = 36
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [WIDTH-1:0]    push_data,
  input  logic                pop,
  output logic [WIDTH-1:0]    pop_data,
  output itra_pkg::q_status_t status
);

  localparam int PTR_W = $clog2(itra_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(itra_pkg::QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] entries [itra_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  // Entry storage; pointers wrap naturally since the depth is a power of two.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign pop_data     = entries[rd_ptr];
  assign status.full  = (count == CNT_W'(itra_pkg::QUEUE_DEPTH));
  assign status.empty = (count == '0);

endmodule

// File: hw/rtl/itra_back.sv
// Back end of the converter: chunked divider by the radix, digit store and
// character emitter, most significant digit first. Depends on itra_pkg.

module itra_back #(
  parameter int VALUE_BITS = 31,
  parameter int MAX_DIGITS = 31
) (
  input  logic                          clk,
  input  logic                          rst,
  input  itra_pkg::q_status_t           q_status,
  output logic                          pop,
  input  logic [VALUE_BITS-1:0]         job_value,
  input  logic [itra_pkg::RADIX_W-1:0]  job_radix,
  output logic                          strobe,
  output logic [itra_pkg::CHAR_W-1:0]   digit_char,
  output logic                          last_digit
);

  localparam int CHUNK    = itra_pkg::CHUNK_BITS;
  localparam int PAD_BITS = ((VALUE_BITS + CHUNK - 1) / CHUNK) * CHUNK;
  localparam int NCHUNK   = PAD_BITS / CHUNK;
  localparam int CH_W     = $clog2(NCHUNK + 1);
  localparam int IDX_W    = $clog2(MAX_DIGITS);
  localparam int CNT_W    = $clog2(MAX_DIGITS + 1);
  localparam int DW       = itra_pkg::DIGIT_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_EMIT
  } state_t;

  state_t                       state;
  logic [PAD_BITS-1:0]          work;
  logic [PAD_BITS-1:0]          work_next;
  logic [DW-1:0]                rem;
  logic [DW-1:0]                rem_next;
  logic [itra_pkg::RADIX_W-1:0] rdx;
  logic [CH_W-1:0]              chunk;
  logic [CNT_W-1:0]             cnt;
  logic [IDX_W-1:0]             rd_ptr;
  logic [DW-1:0]                rd_data;
  logic [DW-1:0]                store [MAX_DIGITS];
  logic [CHUNK-1:0]             qbits;
  logic [DW:0]                  partial;
  logic                         chunk_end;

  assign pop       = (state == ST_IDLE) && !q_status.empty;
  assign chunk_end = (chunk == CH_W'(NCHUNK - 1));

  // One chunk of restoring long division by the radix, MSB first.
  always_comb begin
    partial = {1'b0, rem};
    for (int i = 0; i < CHUNK; i++) begin
      partial = {partial[DW-1:0], work[PAD_BITS-1-i]};
      if (partial >= rdx) begin
        partial              = partial - rdx;
        qbits[CHUNK-1-i]     = 1'b1;
      end else begin
        qbits[CHUNK-1-i]     = 1'b0;
      end
    end
    rem_next  = partial[DW-1:0];
    work_next = (work << CHUNK) | PAD_BITS'(qbits);
  end

  // Sequencer with the registered result outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      strobe     <= 1'b0;
      last_digit <= 1'b0;
    end else begin
      strobe     <= 1'b0;
      last_digit <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (pop) begin
            work  <= PAD_BITS'(job_value);
            rdx   <= job_radix;
            rem   <= '0;
            chunk <= '0;
            cnt   <= '0;
            state <= ST_DIVIDE;
          end
        end
        ST_DIVIDE: begin
          work <= work_next;
          if (chunk_end) begin
            // One digit done; stop on a zero quotient or a full store.
            rem   <= '0;
            chunk <= '0;
            cnt   <= cnt + 1'b1;
            if (work_next == '0 || cnt == CNT_W'(MAX_DIGITS - 1)) begin
              rd_ptr <= cnt[IDX_W-1:0];
              state  <= ST_EMIT;
            end
          end else begin
            rem   <= rem_next;
            chunk <= chunk + 1'b1;
          end
        end
        ST_EMIT: begin
          strobe     <= 1'b1;
          last_digit <= (rd_ptr == '0);
          if (rd_ptr == '0) begin
            state <= ST_IDLE;
          end else begin
            rd_ptr <= rd_ptr - 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Digit store: written as each remainder settles, read back in reverse.
  always_ff @(posedge clk) begin
    if (state == ST_DIVIDE && chunk_end) begin
      store[cnt[IDX_W-1:0]] <= rem_next;
    end
    if (state == ST_EMIT) begin
      rd_data <= store[rd_ptr];
    end
  end

  assign digit_char = itra_pkg::glyph(rd_data);

  // The running remainder always stays below the radix.
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIVIDE) |-> (rem < rdx))
    else $error("remainder not below radix");

  // Digit writes stay inside the store.
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIVIDE) |-> (cnt < CNT_W'(MAX_DIGITS)))
    else $error("digit index beyond store");

  // The final-character flag only rides on a strobed word.
  a_last_strobe: assert property (@(posedge clk) disable iff (rst)
    last_digit |-> strobe)
    else $error("last_digit without strobe");

  // A number's final character is never followed at once by another.
  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && last_digit) |=> !strobe)
    else $error("character right after final character");

endmodule

// File: hw/rtl/integer_to_radix_ascii_top.sv
// Top level of the integer to radix ASCII converter.
// Depends on itra_pkg, itra_front, itra_queue and itra_back.

// Usage:
// Command channel: a word on value is taken at a rising edge with start high
// and busy low. Busy rises only when the two-entry job queue is full.
// Configuration channel: cfg_radix is written at an edge with cfg_valid and
// cfg_ready high; cfg_ready is always high. Values 0 and 1 act as radix 2,
// values above 16 act as radix 16. The radix is sampled when a word is taken.
// Result channel: one character per cycle in which strobe is high, most
// significant digit first, with last_digit marking the final character.
// The receiver cannot stall; every strobed word must be taken.
// Timing: the divider resolves 8 quotient bits a cycle and divides the whole
// value by the radix once for each digit. The digits are divided one after
// another and then emitted; a job is taken from the queue only while idle.
// Conversions run one at a time, so with words waiting in the queue a new
// number starts only after the final character of the previous one.
// The queue lets new words be taken while a conversion is in progress.
// Reset: synchronous; radix returns to 10, the queue empties, no strobe.

module integer_to_radix_ascii_top #(
  parameter int VALUE_BITS = 31,
  parameter int MAX_DIGITS = 31
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [VALUE_BITS-1:0]        value,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [itra_pkg::RADIX_W-1:0] cfg_radix,
  output logic                         strobe,
  output logic [itra_pkg::CHAR_W-1:0]  digit_char,
  output logic                         last_digit
);

  localparam int JOB_W = VALUE_BITS + itra_pkg::RADIX_W;

  itra_pkg::q_status_t          q_status;
  logic                         push;
  logic                         pop;
  logic [VALUE_BITS-1:0]        push_value;
  logic [itra_pkg::RADIX_W-1:0] push_radix;
  logic [JOB_W-1:0]             pop_data;

  // Command intake and radix register.
  itra_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .value      (value),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_radix  (cfg_radix),
    .q_status   (q_status),
    .push       (push),
    .push_value (push_value),
    .push_radix (push_radix)
  );

  // Job queue carrying value and clamped radix.
  itra_queue #(
    .WIDTH (JOB_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_radix, push_value}),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  // Divider, digit store and character emitter.
  itra_back #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_status   (q_status),
    .pop        (pop),
    .job_value  (pop_data[VALUE_BITS-1:0]),
    .job_radix  (pop_data[JOB_W-1:VALUE_BITS]),
    .strobe     (strobe),
    .digit_char (digit_char),
    .last_digit (last_digit)
  );

endmodule
